[hw/rtl/fsdp_pkg.sv]
// Types, constants and the control store for the %d format printer.
// No dependencies; used by fsdp_seq, fsdp_dp and the top level.
package fsdp_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // x / 10 == (x * RECIP) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          QUOT_W      = 64 - RECIP_SHIFT;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] S_FETCH    = 4'd0;
  localparam logic [STEP_W-1:0] S_PLAIN    = 4'd1;
  localparam logic [STEP_W-1:0] S_ARMCHK   = 4'd2;
  localparam logic [STEP_W-1:0] S_DCHK     = 4'd3;
  localparam logic [STEP_W-1:0] S_LOAD     = 4'd4;
  localparam logic [STEP_W-1:0] S_MUL      = 4'd5;
  localparam logic [STEP_W-1:0] S_DIV      = 4'd6;
  localparam logic [STEP_W-1:0] S_PREP     = 4'd7;
  localparam logic [STEP_W-1:0] S_MINUS    = 4'd8;
  localparam logic [STEP_W-1:0] S_DIGIT    = 4'd9;
  localparam logic [STEP_W-1:0] S_DONE     = 4'd10;
  localparam logic [STEP_W-1:0] S_ECHO     = 4'd11;
  localparam logic [STEP_W-1:0] S_ARM      = 4'd12;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLRPEND,
    OP_SETPEND,
    OP_LOADMAG,
    OP_MUL,
    OP_DIV,
    OP_PREP,
    OP_EMIT_MINUS,
    OP_EMIT_DIGIT,
    OP_EMIT_CHAR
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOACC,
    C_PLAIN,
    C_NOPEND,
    C_NOTD,
    C_MORE,
    C_NOTNEG,
    C_IDX_NZ
  } cond_t;

  typedef struct packed {
    logic              in_rdy;
    logic              wait_out;
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  // sequencer -> datapath
  typedef struct packed {
    op_t  op;
    logic fire;
    logic take;
  } ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic plain;
    logic nopend;
    logic not_d;
    logic more;
    logic not_neg;
    logic idx_nz;
    logic out_busy;
  } status_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{in_rdy: 1'b0, wait_out: 1'b0, op: OP_NONE, cond: C_ALWAYS, target: S_FETCH};
    case (step)
      S_FETCH:  begin w.in_rdy = 1'b1; w.cond = C_NOACC; w.target = S_FETCH; end
      S_PLAIN:  begin w.cond = C_PLAIN;  w.target = S_ECHO; end
      S_ARMCHK: begin w.cond = C_NOPEND; w.target = S_ARM;  end
      S_DCHK:   begin w.op = OP_CLRPEND; w.cond = C_NOTD; w.target = S_FETCH; end
      S_LOAD:   begin w.op = OP_LOADMAG; w.cond = C_NEVER; end
      S_MUL:    begin w.op = OP_MUL;     w.cond = C_NEVER; end
      S_DIV:    begin w.op = OP_DIV;     w.cond = C_MORE;  w.target = S_MUL; end
      S_PREP:   begin w.op = OP_PREP;    w.cond = C_NOTNEG; w.target = S_DIGIT; end
      S_MINUS:  begin w.op = OP_EMIT_MINUS; w.wait_out = 1'b1; w.cond = C_NEVER; end
      S_DIGIT:  begin
        w.op = OP_EMIT_DIGIT; w.wait_out = 1'b1; w.cond = C_IDX_NZ; w.target = S_DIGIT;
      end
      S_DONE:   begin w.cond = C_ALWAYS; w.target = S_FETCH; end
      S_ECHO:   begin w.op = OP_EMIT_CHAR; w.wait_out = 1'b1; w.target = S_FETCH; end
      S_ARM:    begin w.op = OP_SETPEND; w.target = S_FETCH; end
      default:  begin w.cond = C_ALWAYS; w.target = S_FETCH; end
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/fsdp_stream_if.sv]
// Valid/ready channel interfaces for the format byte requests and the
// character results. Depends on nothing.
interface fsdp_fmt_if;
  logic               valid;
  logic               ready;
  logic [7:0]         fmt_char;
  logic signed [31:0] arg_value;
  modport source(output valid, fmt_char, arg_value, input ready);
  modport sink(input valid, fmt_char, arg_value, output ready);
endinterface

interface fsdp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;
  modport source(output valid, out_char, last_of_run, input ready);
  modport sink(input valid, out_char, last_of_run, output ready);
endinterface

[hw/rtl/fsdp_seq.sv]
// Microcode sequencer: step counter, control store lookup, branch logic.
// Depends on fsdp_pkg.
module fsdp_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  fsdp_pkg::status_t   st,
  output fsdp_pkg::ctrl_t     ctrl
);

  logic [fsdp_pkg::STEP_W-1:0] step;
  logic [fsdp_pkg::STEP_W-1:0] step_next;
  fsdp_pkg::uword_t            w;
  logic                        stall;
  logic                        taken;
  logic                        take;

  assign w         = fsdp_pkg::ucode(step);
  assign req_ready = w.in_rdy;
  assign take      = req_valid && w.in_rdy;
  assign stall     = w.wait_out && st.out_busy;

  always_comb begin
    case (w.cond)
      fsdp_pkg::C_NEVER:  taken = 1'b0;
      fsdp_pkg::C_ALWAYS: taken = 1'b1;
      fsdp_pkg::C_NOACC:  taken = !take;
      fsdp_pkg::C_PLAIN:  taken = st.plain;
      fsdp_pkg::C_NOPEND: taken = st.nopend;
      fsdp_pkg::C_NOTD:   taken = st.not_d;
      fsdp_pkg::C_MORE:   taken = st.more;
      fsdp_pkg::C_NOTNEG: taken = st.not_neg;
      fsdp_pkg::C_IDX_NZ: taken = st.idx_nz;
      default:            taken = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      step_next = step;
    end else if (taken) begin
      step_next = w.target;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= fsdp_pkg::S_FETCH;
    end else begin
      step <= step_next;
    end
  end

  assign ctrl.op   = w.op;
  assign ctrl.fire = !stall;
  assign ctrl.take = take;

endmodule

[hw/rtl/fsdp_dp.sv]
// Datapath: request latch, pending flag, reciprocal divide-by-ten,
// digit store and the output character register. Depends on fsdp_pkg.
module fsdp_dp #(
  parameter int MAX_DIGITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  fsdp_pkg::ctrl_t    ctrl,
  input  logic [7:0]         fmt_char,
  input  logic signed [31:0] arg_value,
  input  logic               res_ready,
  output fsdp_pkg::status_t  st,
  output logic               res_valid,
  output logic [7:0]         out_char,
  output logic               res_last
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  logic [7:0]                    char_reg;
  logic [31:0]                   arg_reg;
  logic                          pend;
  logic                          neg;
  logic [31:0]                   mag;
  logic [63:0]                   prod;
  logic [CNT_W-1:0]              ndig;
  logic [IDX_W-1:0]              idx;
  logic [3:0]                    rd_data;
  logic [3:0]                    store [MAX_DIGITS];

  logic [fsdp_pkg::QUOT_W-1:0]   quot;
  logic [31:0]                   quot10;
  logic [31:0]                   rem;
  logic [CNT_W-1:0]              ndig_inc;
  logic [CNT_W-1:0]              ndig_dec;
  logic [IDX_W-1:0]              idx_dec;
  logic                          fire;

  assign fire     = ctrl.fire;
  assign quot     = prod[63:fsdp_pkg::RECIP_SHIFT];
  assign quot10   = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem      = mag - quot10;
  assign ndig_inc = ndig + 1'b1;
  assign ndig_dec = ndig - 1'b1;
  assign idx_dec  = idx - 1'b1;

  assign st.plain    = !pend && (char_reg != fsdp_pkg::CH_PERCENT);
  assign st.nopend   = !pend;
  assign st.not_d    = char_reg != fsdp_pkg::CH_D;
  assign st.more     = (quot != '0) && (ndig_inc < CNT_W'(MAX_DIGITS));
  assign st.not_neg  = !neg;
  assign st.idx_nz   = idx != '0;
  assign st.out_busy = res_valid && !res_ready;

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      char_reg <= fmt_char;
      arg_reg  <= arg_value;
    end
    if (fire) begin
      case (ctrl.op)
        fsdp_pkg::OP_LOADMAG: begin
          neg  <= arg_reg[31];
          mag  <= arg_reg[31] ? (32'd0 - arg_reg) : arg_reg;
          ndig <= '0;
        end
        fsdp_pkg::OP_MUL: begin
          prod <= mag * fsdp_pkg::RECIP;
        end
        fsdp_pkg::OP_DIV: begin
          store[ndig[IDX_W-1:0]] <= rem[3:0];
          mag  <= {{(32 - fsdp_pkg::QUOT_W){1'b0}}, quot};
          ndig <= ndig_inc;
        end
        fsdp_pkg::OP_PREP: begin
          idx     <= ndig_dec[IDX_W-1:0];
          rd_data <= store[ndig_dec[IDX_W-1:0]];
        end
        fsdp_pkg::OP_EMIT_DIGIT: begin
          if (idx != '0) begin
            idx     <= idx_dec;
            rd_data <= store[idx_dec];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (fire && ctrl.op == fsdp_pkg::OP_SETPEND) begin
      pend <= 1'b1;
    end else if (fire && ctrl.op == fsdp_pkg::OP_CLRPEND) begin
      pend <= 1'b0;
    end
  end

  // output holding register; emit steps are held off by the sequencer while it is full and not being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && (ctrl.op == fsdp_pkg::OP_EMIT_MINUS ||
                          ctrl.op == fsdp_pkg::OP_EMIT_DIGIT ||
                          ctrl.op == fsdp_pkg::OP_EMIT_CHAR)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      case (ctrl.op)
        fsdp_pkg::OP_EMIT_MINUS: begin
          out_char <= fsdp_pkg::CH_MINUS;
          res_last <= 1'b0;
        end
        fsdp_pkg::OP_EMIT_DIGIT: begin
          out_char <= fsdp_pkg::ASCII_ZERO + {4'd0, rd_data};
          res_last <= (idx == '0);
        end
        fsdp_pkg::OP_EMIT_CHAR: begin
          out_char <= char_reg;
          res_last <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[hw/rtl/format_string_decimal_printer_unit.sv]
// Top level of the %d format printer: sequencer plus datapath.
// Depends on fsdp_pkg, fsdp_stream_if, fsdp_seq and fsdp_dp.
//
// Takes one format byte with its argument per request and returns the
// characters it produces, one per cycle while the sink keeps accepting
// them. An ordinary byte is echoed, a '%' sets the pending flag and a
// byte after '%' other than 'd' is dropped. For a "%d" each digit needs
// two steps of the single 32x32 reciprocal multiplier (multiply, then
// remainder and store), and the digits, after any minus sign, then leave
// the output register one per cycle while the sink keeps accepting them.
// A new request is taken only between runs, but also while the last
// character still waits in the output register.
module format_string_decimal_printer_unit #(
  parameter int MAX_DIGITS = 10
) (
  input logic               clk,
  input logic               rst,
  fsdp_fmt_if.sink          fmt_req,
  fsdp_char_if.source       char_res
);

  fsdp_pkg::ctrl_t   ctrl;
  fsdp_pkg::status_t st;

  fsdp_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (fmt_req.valid),
    .req_ready (fmt_req.ready),
    .st        (st),
    .ctrl      (ctrl)
  );

  fsdp_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .fmt_char  (fmt_req.fmt_char),
    .arg_value (fmt_req.arg_value),
    .res_ready (char_res.ready),
    .st        (st),
    .res_valid (char_res.valid),
    .out_char  (char_res.out_char),
    .res_last  (char_res.last_of_run)
  );

endmodule

[hw/rtl/fsdp_checker.sv]
// Port-level checks for the %d format printer, bound to the top level.
// Depends on format_string_decimal_printer_unit.
module fsdp_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] out_char,
  input logic       res_last
);

  // a result held back by the sink stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_char) && $stable(res_last))
    else $error("output changed while stalled");

  // only a sign or a digit can be followed by more of the same run
  a_mid_char: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |->
      out_char == 8'h2D || (out_char >= 8'h30 && out_char <= 8'h39))
    else $error("non-final character is not a sign or digit");

  // decode follows each request, so none is taken in the cycle after another
  a_no_b2b: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken in consecutive cycles");

  // the first character of any request cannot appear the cycle after it
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(res_valid))
    else $error("output too early after request");

endmodule

bind format_string_decimal_printer_unit fsdp_checker u_fsdp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (fmt_req.valid),
  .req_ready (fmt_req.ready),
  .res_valid (char_res.valid),
  .res_ready (char_res.ready),
  .out_char  (char_res.out_char),
  .res_last  (char_res.last_of_run)
);
